[rtl/srgfp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the segment row gap flag packer.
// No dependencies; every other file but srgfp_stream_if imports this package.
package srgfp_pkg;

  // Item codes
  localparam logic OP_ROW   = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  localparam int unsigned ROW_IDX_W  = 32;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned GSIZE_W    = 7;
  localparam int unsigned FLAG_POS_W = 6;
  localparam logic [GSIZE_W-1:0] GSIZE_RESET = 7'd32;
  localparam logic [GSIZE_W-1:0] GSIZE_MAX   = 7'd64;

  // Depth of the flag queue between front and back
  localparam int unsigned FQ_DEPTH = 2;
  localparam int unsigned FQ_PTR_W = 1;
  localparam int unsigned FQ_CNT_W = 2;

  typedef struct packed {
    logic                 opcode;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 last_segment;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] flag_word;
    logic              word_last;
  } word_t;

  typedef struct packed {
    logic [GSIZE_W-1:0] group_size;
  } cfg_t;

  // One closed segment, handed from front to back
  typedef struct packed {
    logic gap;
    logic last;
  } flag_t;

endpackage

[rtl/srgfp_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload of a chosen type.
// Payload types come from srgfp_pkg.
interface srgfp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/srgfp_front.sv]
`timescale 1ns / 1ps
// Front end: accepts items, compares row indices within a segment and
// pushes one flag per closed segment. Depends on srgfp_pkg, srgfp_stream_if.
module srgfp_front
  import srgfp_pkg::*;
#(
  parameter int unsigned ROW_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  srgfp_stream_if.sink   item_i,
  input  logic           fq_full_i,
  output logic           push_o,
  output flag_t          push_flag_o
);

  localparam int unsigned DW = (ROW_WIDTH > ROW_IDX_W) ? ROW_WIDTH : ROW_IDX_W;

  logic [ROW_IDX_W-1:0] prev_row_q, prev_row_d;
  logic                 have_prev_q, have_prev_d;
  logic                 gap_seen_q, gap_seen_d;
  logic [DW-1:0]        cur_ext, prev_ext, diff_full;
  logic [ROW_WIDTH-1:0] diff;
  logic                 accept, is_gap;

  assign item_i.ready = !fq_full_i;
  assign accept       = item_i.valid && item_i.ready;

  // Difference wraps modulo 2^ROW_WIDTH
  assign cur_ext   = DW'(item_i.payload.row_index);
  assign prev_ext  = DW'(prev_row_q);
  assign diff_full = cur_ext - prev_ext;
  assign diff      = diff_full[ROW_WIDTH-1:0];
  assign is_gap    = have_prev_q && (diff > ROW_WIDTH'(1));

  always_comb begin
    prev_row_d  = prev_row_q;
    have_prev_d = have_prev_q;
    gap_seen_d  = gap_seen_q;
    push_o      = 1'b0;
    push_flag_o = '{gap: gap_seen_q, last: item_i.payload.last_segment};
    if (accept) begin
      if (item_i.payload.opcode == OP_CLOSE) begin
        push_o      = 1'b1;
        have_prev_d = 1'b0;
        gap_seen_d  = 1'b0;
      end else begin
        prev_row_d  = item_i.payload.row_index;
        have_prev_d = 1'b1;
        gap_seen_d  = gap_seen_q | is_gap;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_row_q  <= '0;
      have_prev_q <= 1'b0;
      gap_seen_q  <= 1'b0;
    end else begin
      prev_row_q  <= prev_row_d;
      have_prev_q <= have_prev_d;
      gap_seen_q  <= gap_seen_d;
    end
  end

endmodule

[rtl/srgfp_fifo.sv]
`timescale 1ns / 1ps
// Short flag queue between front and back.
// Depends on srgfp_pkg.
module srgfp_fifo
  import srgfp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  flag_t push_flag_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output flag_t pop_flag_o
);

  flag_t               mem_q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FQ_CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == FQ_CNT_W'(FQ_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_flag_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && valid_o)) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i && valid_o) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_flag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

[rtl/srgfp_back.sv]
`timescale 1ns / 1ps
// Back end: packs segment flags into words, holds the group size register
// and drives the output register. Depends on srgfp_pkg, srgfp_stream_if.
module srgfp_back
  import srgfp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  srgfp_stream_if.sink   cfg_i,
  input  logic           fq_valid_i,
  input  flag_t          fq_flag_i,
  output logic           pop_o,
  srgfp_stream_if.source word_o
);

  logic [GSIZE_W-1:0] group_size_q;
  logic [GSIZE_W-1:0] eff_size;
  logic [WORD_W-1:0]  packed_q, packed_d, packed_ins;
  logic [GSIZE_W-1:0] held_q, held_d, held_inc;
  logic               out_valid_q, out_valid_d;
  word_t              out_q, out_d;
  logic               emit;

  assign cfg_i.ready = 1'b1;

  // Zero acts as one, anything above the word width acts as the width
  always_comb begin
    if (group_size_q == '0) begin
      eff_size = GSIZE_W'(1);
    end else if (group_size_q > GSIZE_MAX) begin
      eff_size = GSIZE_MAX;
    end else begin
      eff_size = group_size_q;
    end
  end

  assign pop_o      = fq_valid_i && (!out_valid_q || word_o.ready);
  assign packed_ins = packed_q | (WORD_W'(fq_flag_i.gap) << held_q[FLAG_POS_W-1:0]);
  assign held_inc   = held_q + 1'b1;
  assign emit       = fq_flag_i.last || (held_inc >= eff_size);

  always_comb begin
    packed_d    = packed_q;
    held_d      = held_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (word_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      if (emit) begin
        out_d       = '{flag_word: packed_ins, word_last: fq_flag_i.last};
        out_valid_d = 1'b1;
        packed_d    = '0;
        held_d      = '0;
      end else begin
        packed_d = packed_ins;
        held_d   = held_inc;
      end
    end
  end

  assign word_o.valid   = out_valid_q;
  assign word_o.payload = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GSIZE_RESET;
      packed_q     <= '0;
      held_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        group_size_q <= cfg_i.payload.group_size;
      end
      packed_q    <= packed_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/segment_row_gap_flag_packer.sv]
`timescale 1ns / 1ps
// Segment row gap flag packer, top level.
// Depends on srgfp_pkg, srgfp_stream_if, srgfp_front, srgfp_fifo, srgfp_back.
//
// Usage:
//   item_i  - request stream of row indices (opcode row) and segment
//             closes (opcode close, last_segment marks the final segment).
//   word_o  - packed gap flags, one bit per closed segment from bit 0 up;
//             word_last is set on the word holding the final segment's flag.
//   cfg_i   - group size write, always ready; write only while idle.
// Throughput: one request per cycle, sustained, as long as word_o is taken.
// Path: a close that completes a word is written into the flag queue when
//   it is accepted, then loaded into the output register, from which
//   word_o hands it over.
// The front holds the segment compare state; a two entry flag queue
// decouples it from the back, which packs flags and owns the output
// register. When word_o stalls the back holds its word, the queue fills
// and item_i drops ready only once the queue is full.
// Reset clears all segment and packing state and sets group size to 32.
module segment_row_gap_flag_packer
  import srgfp_pkg::*;
#(
  parameter int unsigned ROW_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  srgfp_stream_if.sink   item_i,
  srgfp_stream_if.sink   cfg_i,
  srgfp_stream_if.source word_o
);

  logic  push, fq_full, fq_valid, pop;
  flag_t push_flag, fq_flag;

  // Advance segment state and classify each request
  srgfp_front #(
    .ROW_WIDTH (ROW_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .fq_full_i   (fq_full),
    .push_o      (push),
    .push_flag_o (push_flag)
  );

  // Hold closed segment flags until the back can take them
  srgfp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_flag_i (push_flag),
    .full_o      (fq_full),
    .pop_i       (pop),
    .valid_o     (fq_valid),
    .pop_flag_o  (fq_flag)
  );

  // Pack flags and emit words
  srgfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .fq_valid_i (fq_valid),
    .fq_flag_i  (fq_flag),
    .pop_o      (pop),
    .word_o     (word_o)
  );

endmodule

[sim/segment_row_gap_flag_packer_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for segment_row_gap_flag_packer: random and directed requests,
// with an in-bench prediction of every packed flag word.
// Depends on srgfp_pkg, srgfp_stream_if and the packer RTL.
module segment_row_gap_flag_packer_test;
  import srgfp_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;    // quiet cycles before a group size write
  localparam int unsigned TAIL_CYCLES    = 10;   // drain time after the last word
  localparam int unsigned SQUEEZE_CYCLES = 150;  // one long receiver hold-off
  localparam int unsigned BURST_REQS     = 90;   // back-to-back requests during it
  localparam int unsigned IDLE_LIMIT     = 2000; // cycles without any handshake
  localparam int unsigned PHASE_REQS     = 120;
  localparam int unsigned NUM_PHASES     = 10;
  localparam logic [GSIZE_W-1:0] PHASE_SIZES [NUM_PHASES] =
    '{7'd2, 7'd1, 7'd64, 7'd5, 7'd127, 7'd0, 7'd32, 7'd65, 7'd3, 7'd17};

  // What the sender does next: offer a request, write the group size, wait until
  // no word is due any more, or start the receiver's long hold-off.
  typedef enum logic [1:0] {
    ACT_REQ,
    ACT_CFG,
    ACT_SETTLE,
    ACT_SQUEEZE
  } act_kind_e;

  typedef struct {
    act_kind_e kind;
    item_t     req;
    cfg_t      cfg;
  } act_t;

  logic clk_i;
  logic rst_ni;

  srgfp_stream_if #(.payload_t(item_t)) item_if ();
  srgfp_stream_if #(.payload_t(cfg_t))  cfg_if ();
  srgfp_stream_if #(.payload_t(word_t)) word_if ();

  segment_row_gap_flag_packer #(
    .ROW_WIDTH(ROW_IDX_W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item_if),
    .cfg_i (cfg_if),
    .word_o(word_if)
  );

  act_t        send_plan[$];
  word_t       words_due[$];
  int unsigned req_count;
  int unsigned mismatches;

  // Predicted state of the packer
  logic [ROW_IDX_W-1:0] seg_prev_row = '0;
  logic                 seg_has_row  = 1'b0;
  logic                 seg_gap      = 1'b0;
  logic [WORD_W-1:0]    word_bits    = '0;
  logic [GSIZE_W-1:0]   word_fill    = '0;
  logic [GSIZE_W-1:0]   group_size_q = GSIZE_RESET;

  // Sender and receiver bookkeeping
  int unsigned send_gap;
  int unsigned burst_left;
  int unsigned settle_count;
  int unsigned src_cycle;
  int unsigned snk_cycle;
  int unsigned hold_left;
  int unsigned idle_cycles;
  logic        squeeze_req;
  logic        squeeze_done;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hold every input at a known value from time zero; release reset once.
  initial begin
    rst_ni          = 1'b0;
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    word_if.ready   = 1'b0;
    squeeze_req     = 1'b0;
    squeeze_done    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly short gaps, a few long ones; none at all when steady.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatches++;
    $display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Fold one accepted request into the predicted state; queue the word a close
  // completes. Rows are compared only within a segment, modulo the row width.
  task automatic pack_gap_flags(input item_t req);
    logic [ROW_IDX_W-1:0] diff;
    logic [GSIZE_W-1:0]   limit;
    word_t                word;
    if (req.opcode == OP_ROW) begin
      if (seg_has_row) begin
        diff = req.row_index - seg_prev_row;
        if (diff > 1) seg_gap = 1'b1;
      end
      seg_prev_row = req.row_index;
      seg_has_row  = 1'b1;
    end else begin
      if (seg_gap) word_bits[word_fill[FLAG_POS_W-1:0]] = 1'b1;
      word_fill   = word_fill + 1'b1;
      seg_has_row = 1'b0;
      seg_gap     = 1'b0;
      // a size of zero packs one flag, anything above the word width packs a full word
      limit = (group_size_q == 0) ? GSIZE_W'(1) :
              (group_size_q > GSIZE_MAX) ? GSIZE_MAX : group_size_q;
      if (req.last_segment || word_fill >= limit) begin
        word.flag_word = word_bits;
        word.word_last = req.last_segment;
        words_due = {words_due, word};
        word_bits = '0;
        word_fill = '0;
      end
    end
  endtask

  task automatic add_row(input logic [ROW_IDX_W-1:0] row, input logic last);
    act_t a;
    a.kind = ACT_REQ;
    a.req.opcode = OP_ROW;
    a.req.row_index = row;
    a.req.last_segment = last;
    a.cfg = '0;
    send_plan = {send_plan, a};
    req_count++;
  endtask

  task automatic add_close(input logic last);
    act_t a;
    a.kind = ACT_REQ;
    a.req.opcode = OP_CLOSE;
    a.req.row_index = $urandom;  // ignored on a close
    a.req.last_segment = last;
    a.cfg = '0;
    send_plan = {send_plan, a};
    req_count++;
  endtask

  task automatic add_marker(input act_kind_e kind, input logic [GSIZE_W-1:0] size);
    act_t a;
    a.kind = kind;
    a.req = '0;
    a.cfg.group_size = size;
    send_plan = {send_plan, a};
  endtask

  // Quiet the block, then write a new group size
  task automatic add_group_size(input logic [GSIZE_W-1:0] size);
    add_marker(ACT_SETTLE, '0);
    add_marker(ACT_CFG, size);
  endtask

  // One segment: mostly runs of equal or consecutive rows, with the odd jump,
  // backwards step or wild value; rows near the top of the range now and then.
  task automatic add_segment();
    int unsigned          rows;
    int unsigned          r;
    logic [ROW_IDX_W-1:0] row;
    rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
    r = $urandom_range(0, 9);
    if (r < 6) row = $urandom;
    else if (r < 8) row = '1 - $urandom_range(0, 4);
    else row = $urandom_range(0, 4);
    for (int unsigned i = 0; i < rows; i++) begin
      add_row(row, $urandom_range(0, 15) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) row = row + 1;
      else if (r < 80) row = row;
      else if (r < 88) row = row + $urandom_range(2, 1000);
      else if (r < 93) row = row - $urandom_range(1, 3);
      else row = $urandom;
    end
    add_close($urandom_range(0, 11) == 0);
  endtask

  // Plan all stimulus, then wait for the last word and give the verdict
  initial begin : stimulus
    int unsigned phase_end;

    // duplicate and consecutive rows keep the segment clean
    add_row(0, 1'b0); add_row(1, 1'b0); add_row(1, 1'b0); add_close(1'b0);
    // a step backwards wraps to a huge difference
    add_row(5, 1'b0); add_row(3, 1'b0); add_close(1'b0);
    // empty segment
    add_close(1'b0);
    // counting over the top of the row range is still consecutive
    add_row('1, 1'b0); add_row(0, 1'b0); add_close(1'b0);
    // the other way round is a gap; flush as the final segment
    add_row(0, 1'b0); add_row('1, 1'b0); add_close(1'b1);
    // last flag on a row does nothing; rows across a close are never compared
    add_row(7, 1'b1); add_row(9, 1'b0); add_close(1'b0);
    add_row(10, 1'b0); add_close(1'b0);
    add_row(50, 1'b0); add_row(51, 1'b0); add_close(1'b1);

    // one flag per word, and a final segment on a full group
    add_group_size(7'd1);
    add_row(3, 1'b0); add_row(8, 1'b0); add_close(1'b0); add_close(1'b1);
    // zero acts as one
    add_group_size(7'd0);
    add_close(1'b0); add_row(2, 1'b0); add_row(100, 1'b0); add_close(1'b1);

    // lower the size while a word is half full: the next close emits at once
    add_group_size(GSIZE_MAX);
    for (int unsigned i = 0; i < 40; i++) begin
      if (i % 3 == 0) begin
        add_row(1, 1'b0); add_row(5, 1'b0);
      end
      add_close(1'b0);
    end
    add_group_size(7'd10);
    add_close(1'b0); add_close(1'b1);

    // a full 64 flag word with the top flag set
    add_group_size(GSIZE_MAX);
    for (int unsigned i = 0; i < 64; i++) begin
      if (i == 63 || $urandom_range(0, 1) == 1) begin
        add_row(9, 1'b0); add_row(20, 1'b0);
      end
      add_close(1'b0);
    end

    for (int unsigned p = 0; p <= NUM_PHASES; p++) begin
      add_group_size((p < NUM_PHASES) ? PHASE_SIZES[p] : GSIZE_W'($urandom_range(0, 127)));
      if (p == 4) begin
        // one word per close while the receiver holds off: back the block up
        add_group_size(7'd1);
        add_marker(ACT_SQUEEZE, '0);
        for (int unsigned i = 0; i < 40; i++) begin
          add_row($urandom, 1'b0);
          add_close(1'b0);
        end
        add_close(1'b1);
        add_group_size(PHASE_SIZES[p]);
      end
      phase_end = req_count + PHASE_REQS;
      while (req_count < phase_end) add_segment();
    end

    do @(negedge clk_i);
    while (send_plan.size() != 0 || item_if.valid || cfg_if.valid || words_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Sender: hold a request until it is taken, then advance through the plan
  always @(posedge clk_i) begin
    logic item_busy;
    logic cfg_busy;
    logic next_item_valid;
    logic next_cfg_valid;
    act_t a;
    if (rst_ni) begin
      src_cycle++;
      item_busy       = item_if.valid && !item_if.ready;
      cfg_busy        = cfg_if.valid && !cfg_if.ready;
      next_item_valid = item_busy;
      next_cfg_valid  = cfg_busy;
      if (!item_busy && !cfg_busy) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (send_plan.size() != 0) begin
          a = send_plan[0];
          case (a.kind)
            ACT_REQ: begin
              void'(send_plan.pop_front());
              item_if.payload <= a.req;
              next_item_valid = 1'b1;
              if (burst_left != 0) burst_left--;
              else send_gap = pick_gap((src_cycle / 256) % 4 == 0);
            end
            ACT_CFG: begin
              void'(send_plan.pop_front());
              cfg_if.payload <= a.cfg;
              next_cfg_valid = 1'b1;
            end
            ACT_SETTLE: begin
              // count quiet cycles once the channels are idle and no word is due
              if (!item_if.valid && !cfg_if.valid && words_due.size() == 0) settle_count++;
              else settle_count = 0;
              if (settle_count >= SETTLE_CYCLES) begin
                void'(send_plan.pop_front());
                settle_count = 0;
              end
            end
            ACT_SQUEEZE: begin
              void'(send_plan.pop_front());
              squeeze_req <= 1'b1;
              burst_left = BURST_REQS;
            end
            default: void'(send_plan.pop_front());
          endcase
        end
      end
      item_if.valid <= next_item_valid;
      cfg_if.valid  <= next_cfg_valid;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      snk_cycle++;
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = SQUEEZE_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        word_if.ready <= 1'b0;
      end else begin
        word_if.ready <= 1'b1;
        hold_left = pick_gap((snk_cycle / 256) % 4 == 2);
      end
    end
  end

  // Checker: compare the word taken at this edge with the oldest one due, then
  // fold in any group size write and request taken at the same edge.
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni) begin
      if (word_if.valid && word_if.ready) begin
        if (words_due.size() == 0) begin
          report_mismatch("word with none due", word_if.payload.flag_word, '0);
        end else begin
          want = words_due.pop_front();
          if (word_if.payload.flag_word !== want.flag_word)
            report_mismatch("flag_word", word_if.payload.flag_word, want.flag_word);
          if (word_if.payload.word_last !== want.word_last)
            report_mismatch("word_last", WORD_W'(word_if.payload.word_last),
                            WORD_W'(want.word_last));
        end
      end
      if (cfg_if.valid && cfg_if.ready) group_size_q = cfg_if.payload.group_size;
      if (item_if.valid && item_if.ready) pack_gap_flags(item_if.payload);
    end
  end

  // Watchdog: drop the run when no handshake happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_if.valid && item_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (word_if.valid && word_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
